/* hdl/brc_pkg.sv */
// Shared types and constants for the bilinear crop/resize block.
// Depends on nothing; imported by the interfaces, the top level and the checker.
`timescale 1ns / 1ps

package brc_pkg;

    // Store geometry and output size
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int OUT_SIDE   = 300;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int IDX_W = (COL_W > ROW_W) ? COL_W : ROW_W;

    // Four parity banks: even/odd column by even/odd row
    localparam int BANK_AW    = COL_W + ROW_W - 2;
    localparam int BANK_DEPTH = 2 ** BANK_AW;
    localparam int PIX_DW     = 24;
    localparam int NUM_BANKS  = 4;

    // 16.16 fixed point
    localparam int FX_SH   = 16;
    localparam int F_W     = FX_SH + 1;
    localparam int FX_ONE  = 65536;
    localparam int FX_HALF = 32768;

    // Coordinate step: (2o+1)*side*65536 / (2*OUT_SIDE)
    localparam int NUM_W  = 21;
    localparam int DEN    = 2 * OUT_SIDE;
    localparam int Q_INT  = FX_ONE / DEN;
    localparam int Q_REM  = FX_ONE % DEN;
    localparam int X_W    = NUM_W + $clog2(DEN);
    localparam int RCP_SH = 32;
    localparam logic [31:0] RCP = 32'((64'd1 << RCP_SH) / DEN);
    localparam int D_W    = NUM_W + FX_SH;
    localparam int S_W    = D_W + 2;
    localparam int I_W    = S_W - FX_SH;

    // Channel arithmetic
    localparam int HSUM_W = 24;
    localparam int VSUM_W = 41;
    localparam int RES_W  = 16;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_CROP_X     = 3'd2,
        CFG_CROP_Y     = 3'd3,
        CFG_CROP_SIDE  = 3'd4
    } brc_cfg_e;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic       op;
        logic [9:0] pix_col;
        logic [9:0] pix_row;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [8:0] out_col;
        logic [8:0] out_row;
    } brc_req_t;

    typedef struct packed {
        logic [RES_W-1:0] res_red;
        logic [RES_W-1:0] res_green;
        logic [RES_W-1:0] res_blue;
    } brc_rsp_t;

    // One axis after mapping: two neighbour indices and the weight
    typedef struct packed {
        logic [IDX_W-1:0] i0;
        logic [IDX_W-1:0] i1;
        logic [F_W-1:0]   f;
    } brc_axis_t;

endpackage

/* hdl/brc_req_if.sv */
// Request channel: pixel writes and sample requests, valid/ready.
// Depends on brc_pkg for the payload type.
`timescale 1ns / 1ps

interface brc_req_if;
    import brc_pkg::*;

    logic     valid;
    logic     ready;
    brc_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/brc_rsp_if.sv */
// Response channel: interpolated RGB results, valid/ready.
// Depends on brc_pkg for the payload type.
`timescale 1ns / 1ps

interface brc_rsp_if;
    import brc_pkg::*;

    logic     valid;
    logic     ready;
    brc_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/brc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first: a read and write of the same entry in one cycle returns old data.
`timescale 1ns / 1ps

module brc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/bilinear_crop_resize.sv */
// Bilinear crop/resize: pixel store in four parity banks plus a sampling pipeline.
// A sample result passes every stage register and then the output register before it is shown.
// Throughput: one transaction per cycle while the output is not stalled; set by the single
// read of each bank per cycle. Pixel writes are stored in the banks from stage 4, in order
// with samples. A stalled result freezes the whole pipeline. Reset clears valids and config
// registers; the pixel banks are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module bilinear_crop_resize (
    input  logic                            clk,
    input  logic                            rst_n,
    brc_req_if.sink                         req,
    brc_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [brc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brc_pkg::CFG_DW-1:0]      cfg_data
);
    import brc_pkg::*;

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------

    // Saturate a configured size into 1..lim
    function automatic logic [IDX_W:0] clamp_dim(input logic [10:0] v, input int lim);
        logic [IDX_W:0] r;
        if (v == '0)
            r = (IDX_W + 1)'(1);
        else if (int'(v) > lim)
            r = (IDX_W + 1)'(lim);
        else
            r = (IDX_W + 1)'(v);
        return r;
    endfunction

    // Source position, clamped indices and clamped weight for one axis
    function automatic brc_axis_t map_axis(input logic [9:0] origin,
                                           input logic [D_W-1:0] d,
                                           input logic [IDX_W-1:0] size_m1);
        logic signed [S_W-1:0] s;
        logic signed [I_W-1:0] fl;
        logic signed [S_W-1:0] fr;
        logic [IDX_W-1:0]      a;
        brc_axis_t             r;
        s  = $signed(S_W'({origin, 16'd0})) + $signed(S_W'(d))
             - $signed(S_W'(FX_HALF));
        fl = s[S_W-1:FX_SH];
        if (fl < 0)
            a = '0;
        else if (fl > $signed({1'b0, size_m1}))
            a = size_m1;
        else
            a = IDX_W'(fl);
        fr = s - $signed(S_W'({a, 16'd0}));
        if (fr < 0)
            r.f = '0;
        else if (fr > FX_ONE)
            r.f = F_W'(FX_ONE);
        else
            r.f = F_W'(fr);
        r.i0 = a;
        r.i1 = (a < size_m1) ? a + 1'b1 : size_m1;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [10:0] src_width_reg;
    logic [10:0] src_height_reg;
    logic [9:0]  crop_x_reg;
    logic [9:0]  crop_y_reg;
    logic [10:0] crop_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 11'd1024;
            src_height_reg <= 11'd1024;
            crop_x_reg     <= '0;
            crop_y_reg     <= '0;
            crop_side_reg  <= 11'd1024;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[10:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[10:0];
                CFG_CROP_X:     crop_x_reg     <= cfg_data[9:0];
                CFG_CROP_Y:     crop_y_reg     <= cfg_data[9:0];
                CFG_CROP_SIDE:  crop_side_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    logic [IDX_W:0]   width_sat;
    logic [IDX_W:0]   height_sat;
    logic [IDX_W-1:0] width_m1;
    logic [IDX_W-1:0] height_m1;

    assign width_sat  = clamp_dim(src_width_reg, MAX_WIDTH);
    assign height_sat = clamp_dim(src_height_reg, MAX_HEIGHT);
    assign width_m1   = IDX_W'(width_sat - 1'b1);
    assign height_m1  = IDX_W'(height_sat - 1'b1);

    // ---------------------------------------------------------------
    // Flow control: whole pipeline moves when the output register frees
    // ---------------------------------------------------------------
    logic     adv;
    logic     out_vld_reg;
    brc_rsp_t out_data_reg;
    brc_rsp_t out_data_next;

    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    // Stage valids
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;

    // ---------------------------------------------------------------
    // Stage 1: (2o+1) * crop_side per axis
    // ---------------------------------------------------------------
    logic             s1_op_reg;
    logic [9:0]       s1_col_reg, s1_row_reg;
    logic [23:0]      s1_rgb_reg;
    logic [NUM_W-1:0] s1_numx_reg, s1_numy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg   <= req.data.op;
            s1_col_reg  <= req.data.pix_col;
            s1_row_reg  <= req.data.pix_row;
            s1_rgb_reg  <= {req.data.in_red, req.data.in_green, req.data.in_blue};
            s1_numx_reg <= NUM_W'({req.data.out_col, 1'b1}) * NUM_W'(crop_side_reg);
            s1_numy_reg <= NUM_W'({req.data.out_row, 1'b1}) * NUM_W'(crop_side_reg);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: split num*65536/DEN into integer multiple and reciprocal estimate
    // ---------------------------------------------------------------
    logic [X_W-1:0]    s1_xx, s1_xy;
    logic [X_W+31:0]   s1_prodx, s1_prody;

    assign s1_xx    = X_W'(s1_numx_reg * X_W'(Q_REM));
    assign s1_xy    = X_W'(s1_numy_reg * X_W'(Q_REM));
    assign s1_prodx = (X_W + 32)'(s1_xx) * (X_W + 32)'(RCP);
    assign s1_prody = (X_W + 32)'(s1_xy) * (X_W + 32)'(RCP);

    logic             s2_op_reg;
    logic [9:0]       s2_col_reg, s2_row_reg;
    logic [23:0]      s2_rgb_reg;
    logic [X_W-1:0]   s2_xx_reg, s2_xy_reg, s2_qex_reg, s2_qey_reg;
    logic [D_W-1:0]   s2_nix_reg, s2_niy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
            s2_rgb_reg <= s1_rgb_reg;
            s2_xx_reg  <= s1_xx;
            s2_xy_reg  <= s1_xy;
            s2_qex_reg <= s1_prodx[X_W+RCP_SH-1:RCP_SH];
            s2_qey_reg <= s1_prody[X_W+RCP_SH-1:RCP_SH];
            s2_nix_reg <= D_W'(s1_numx_reg * D_W'(Q_INT));
            s2_niy_reg <= D_W'(s1_numy_reg * D_W'(Q_INT));
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: correct the quotient estimate by one and form the offset
    // ---------------------------------------------------------------
    logic [X_W-1:0] s2_rx, s2_ry, s2_qx, s2_qy;

    assign s2_rx = s2_xx_reg - X_W'(s2_qex_reg * X_W'(DEN));
    assign s2_ry = s2_xy_reg - X_W'(s2_qey_reg * X_W'(DEN));
    assign s2_qx = s2_qex_reg + X_W'(s2_rx >= X_W'(DEN));
    assign s2_qy = s2_qey_reg + X_W'(s2_ry >= X_W'(DEN));

    logic           s3_op_reg;
    logic [9:0]     s3_col_reg, s3_row_reg;
    logic [23:0]    s3_rgb_reg;
    logic [D_W-1:0] s3_dx_reg, s3_dy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_op_reg  <= s2_op_reg;
            s3_col_reg <= s2_col_reg;
            s3_row_reg <= s2_row_reg;
            s3_rgb_reg <= s2_rgb_reg;
            s3_dx_reg  <= s2_nix_reg + D_W'(s2_qx);
            s3_dy_reg  <= s2_niy_reg + D_W'(s2_qy);
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: source position, clamping, neighbours and weights
    // ---------------------------------------------------------------
    brc_axis_t s3_ax, s3_ay;

    assign s3_ax = map_axis(crop_x_reg, s3_dx_reg, width_m1);
    assign s3_ay = map_axis(crop_y_reg, s3_dy_reg, height_m1);

    logic             s4_op_reg;
    logic [9:0]       s4_col_reg, s4_row_reg;
    logic [23:0]      s4_rgb_reg;
    logic [COL_W-1:0] s4_x0_reg, s4_x1_reg;
    logic [ROW_W-1:0] s4_y0_reg, s4_y1_reg;
    logic [F_W-1:0]   s4_fx_reg, s4_fy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_op_reg  <= s3_op_reg;
            s4_col_reg <= s3_col_reg;
            s4_row_reg <= s3_row_reg;
            s4_rgb_reg <= s3_rgb_reg;
            s4_x0_reg  <= COL_W'(s3_ax.i0);
            s4_x1_reg  <= COL_W'(s3_ax.i1);
            s4_y0_reg  <= ROW_W'(s3_ay.i0);
            s4_y1_reg  <= ROW_W'(s3_ay.i1);
            s4_fx_reg  <= s3_ax.f;
            s4_fy_reg  <= s3_ay.f;
        end
    end

    // Stage valids move with the pipeline; writes drop out after stage 4
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= req.valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg && (s4_op_reg == OP_SAMPLE);
            s6_vld_reg  <= s5_vld_reg;
            out_vld_reg <= s6_vld_reg;
        end
    end

    // ---------------------------------------------------------------
    // Pixel banks: writes and reads both issue from stage 4, so every
    // access meets the store in transaction order
    // ---------------------------------------------------------------
    logic             wr_en;
    logic [COL_W-1:0] wr_col;
    logic [ROW_W-1:0] wr_row;
    logic [1:0]       wr_bank;
    logic [PIX_DW-1:0] bank_rdata [NUM_BANKS];

    assign wr_en   = adv && s4_vld_reg && (s4_op_reg == OP_WRITE)
                     && (int'(s4_col_reg) < MAX_WIDTH) && (int'(s4_row_reg) < MAX_HEIGHT);
    assign wr_col  = COL_W'(s4_col_reg);
    assign wr_row  = ROW_W'(s4_row_reg);
    assign wr_bank = {wr_row[0], wr_col[0]};

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        logic [COL_W-1:0]   rd_col;
        logic [ROW_W-1:0]   rd_row;

        // Each bank serves whichever neighbour has its parity
        assign rd_col = (s4_x0_reg[0] == 1'(b % 2)) ? s4_x0_reg : s4_x1_reg;
        assign rd_row = (s4_y0_reg[0] == 1'(b / 2)) ? s4_y0_reg : s4_y1_reg;

        brc_ram #(
            .WIDTH (PIX_DW),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (wr_en && (wr_bank == 2'(b))),
            .waddr ({wr_row[ROW_W-1:1], wr_col[COL_W-1:1]}),
            .wdata (s4_rgb_reg),
            .re    (adv),
            .raddr ({rd_row[ROW_W-1:1], rd_col[COL_W-1:1]}),
            .rdata (bank_rdata[b])
        );
    end

    // ---------------------------------------------------------------
    // Stage 5: bank data arrives; horizontal pass per channel
    // ---------------------------------------------------------------
    logic           s5_x0p_reg, s5_x1p_reg, s5_y0p_reg, s5_y1p_reg;
    logic [F_W-1:0] s5_fx_reg, s5_fy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_x0p_reg <= s4_x0_reg[0];
            s5_x1p_reg <= s4_x1_reg[0];
            s5_y0p_reg <= s4_y0_reg[0];
            s5_y1p_reg <= s4_y1_reg[0];
            s5_fx_reg  <= s4_fx_reg;
            s5_fy_reg  <= s4_fy_reg;
        end
    end

    logic [PIX_DW-1:0]       p00, p01, p10, p11;
    logic [F_W-1:0]          gx;
    logic [2:0][HSUM_W-1:0]  hz_top, hz_bot;

    assign p00 = bank_rdata[{s5_y0p_reg, s5_x0p_reg}];
    assign p01 = bank_rdata[{s5_y0p_reg, s5_x1p_reg}];
    assign p10 = bank_rdata[{s5_y1p_reg, s5_x0p_reg}];
    assign p11 = bank_rdata[{s5_y1p_reg, s5_x1p_reg}];
    assign gx  = F_W'(FX_ONE) - s5_fx_reg;

    // Channel 0 is red in the top byte
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            hz_top[c] = HSUM_W'(p00[8*(2-c) +: 8]) * HSUM_W'(gx)
                      + HSUM_W'(p01[8*(2-c) +: 8]) * HSUM_W'(s5_fx_reg);
            hz_bot[c] = HSUM_W'(p10[8*(2-c) +: 8]) * HSUM_W'(gx)
                      + HSUM_W'(p11[8*(2-c) +: 8]) * HSUM_W'(s5_fx_reg);
        end
    end

    logic [2:0][HSUM_W-1:0] s6_top_reg, s6_bot_reg;
    logic [F_W-1:0]         s6_fy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_top_reg <= hz_top;
            s6_bot_reg <= hz_bot;
            s6_fy_reg  <= s5_fy_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: vertical pass, keep bits 39:24 as 8.8
    // ---------------------------------------------------------------
    logic [F_W-1:0]         gy;
    logic [2:0][VSUM_W-1:0] vt_sum;

    assign gy = F_W'(FX_ONE) - s6_fy_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            vt_sum[c] = VSUM_W'(s6_top_reg[c]) * VSUM_W'(gy)
                      + VSUM_W'(s6_bot_reg[c]) * VSUM_W'(s6_fy_reg);
        end
        out_data_next.res_red   = vt_sum[0][39:24];
        out_data_next.res_green = vt_sum[1][39:24];
        out_data_next.res_blue  = vt_sum[2][39:24];
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_data_reg;

endmodule

/* hdl/brc_checker.sv */
// Port-level checks for bilinear_crop_resize, attached by bind.
// Depends on brc_pkg for the response type.
`timescale 1ns / 1ps

module brc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input brc_pkg::brc_rsp_t  rsp_data
);
    import brc_pkg::*;

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("result payload changed while stalled");

    // Interpolated channels never exceed 255.0 in 8.8
    a_rsp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.res_red <= 16'hFF00) && (rsp_data.res_green <= 16'hFF00)
                      && (rsp_data.res_blue <= 16'hFF00))
        else $error("result channel out of range");

    // With the output register empty the block always takes a transaction
    a_req_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request refused while output register empty");

endmodule

bind bilinear_crop_resize brc_checker u_brc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

/* tb/tb_bilinear_crop_resize.sv */
// Self-checking testbench for bilinear_crop_resize: pixel writes and bilinear samples.
// Depends on brc_pkg, brc_req_if, brc_rsp_if and the bilinear_crop_resize top level.
`timescale 1ns / 1ps

module tb_bilinear_crop_resize;
    import brc_pkg::*;

    localparam int ITEMS_TOTAL   = 1050;
    localparam int DIRECTED_ROWS = 22;
    localparam int NUM_PLANS     = 10;
    localparam int FIXED_PLANS   = 7;
    localparam int ITEMS_PER_SEG = (ITEMS_TOTAL - DIRECTED_ROWS) / (NUM_PLANS + 1);
    localparam int SETTLE_CYCLES = 12;
    localparam int WATCHDOG_NS   = 5_000_000;
    localparam int REPORT_LIMIT  = 10;

    // One directed row: request, whether the result is typed in, and that result
    typedef struct packed {
        brc_req_t stim;
        logic     known;
        brc_rsp_t want;
    } dir_row_t;

    // Register settings for one segment of the run
    typedef struct packed {
        logic [CFG_DW-1:0] w;
        logic [CFG_DW-1:0] h;
        logic [CFG_DW-1:0] cx;
        logic [CFG_DW-1:0] cy;
        logic [CFG_DW-1:0] side;
    } plan_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DW-1:0]    cfg_data;

    brc_req_if req_ch ();
    brc_rsp_if rsp_ch ();

    bilinear_crop_resize u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block: register copy and the pixels written so far
    logic [10:0] cfg_w    = 11'd1024;
    logic [10:0] cfg_h    = 11'd1024;
    logic [9:0]  cfg_cx   = 10'd0;
    logic [9:0]  cfg_cy   = 10'd0;
    logic [10:0] cfg_side = 11'd1024;
    logic [23:0] src_pixels [int];

    brc_rsp_t pending_rgb [$];
    int       bad_results = 0;
    int       items_sent  = 0;
    bit       calm        = 1'b0;

    // Directed rows, default registers: flat patches, far corner, mixed patch, bottom edge
    dir_row_t directed_tab [DIRECTED_ROWS] = '{
        '{{OP_WRITE, 10'd1, 10'd1, 24'hFFFFFF, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd2, 10'd1, 24'hFFFFFF, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd1, 10'd2, 24'hFFFFFF, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd2, 10'd2, 24'hFFFFFF, 18'd0}, 1'b0, 48'h0},
        '{{OP_SAMPLE, 20'd0, 24'h0, 9'd0, 9'd0}, 1'b1, {3{16'hFF00}}},
        '{{OP_WRITE, 10'd1, 10'd1, 24'h000000, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd2, 10'd1, 24'h000000, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd1, 10'd2, 24'h000000, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd2, 10'd2, 24'h000000, 18'd0}, 1'b0, 48'h0},
        '{{OP_SAMPLE, 20'd0, 24'h0, 9'd0, 9'd0}, 1'b1, 48'h0},
        '{{OP_WRITE, 10'd1023, 10'd1023, 24'hAA550F, 18'd0}, 1'b0, 48'h0},
        '{{OP_SAMPLE, 20'd0, 24'h0, 9'd511, 9'd511}, 1'b1, {16'hAA00, 16'h5500, 16'h0F00}},
        '{{OP_SAMPLE, 20'd0, 24'h0, 9'd300, 9'd300}, 1'b1, {16'hAA00, 16'h5500, 16'h0F00}},
        '{{OP_WRITE, 10'd1, 10'd1, 24'h1080F0, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd2, 10'd1, 24'h2040E0, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd1, 10'd2, 24'hF00133, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd2, 10'd2, 24'h7FFE80, 18'd0}, 1'b0, 48'h0},
        '{{OP_SAMPLE, 20'd0, 24'h0, 9'd0, 9'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd0, 10'd0, 24'h123456, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd1, 10'd1023, 24'hC35A99, 18'd0}, 1'b0, 48'h0},
        '{{OP_WRITE, 10'd2, 10'd1023, 24'h010203, 18'd0}, 1'b0, 48'h0},
        '{{OP_SAMPLE, 20'd0, 24'h0, 9'd0, 9'd511}, 1'b0, 48'h0}
    };

    // Fixed register settings: small image, far corner, zero and saturated sizes,
    // zero crop side, one-column image, odd sizes
    plan_t fixed_plan [FIXED_PLANS] = '{
        '{11'd16,   11'd12,   11'd0,    11'd0,    11'd16},
        '{11'd1024, 11'd1024, 11'd1000, 11'd1000, 11'd24},
        '{11'd0,    11'd0,    11'd5,    11'd7,    11'd1},
        '{11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047},
        '{11'd20,   11'd20,   11'd10,   11'd3,    11'd0},
        '{11'd1,    11'd1024, 11'd0,    11'd500,  11'd1024},
        '{11'd37,   11'd29,   11'd3,    11'd2,    11'd30}
    };

    // Image size as the block sees it: zero acts as one, large values saturate
    function automatic longint eff_extent(input logic [10:0] v, input int lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return longint'(v);
    endfunction

    // Output position to neighbour indices and weight along one axis
    function automatic void map_axis(input logic [9:0] origin, input logic [8:0] pos,
                                     input longint extent, output longint lo,
                                     output longint hi, output longint wt);
        longint num;
        longint s;
        longint a;
        num = (2 * longint'(pos) + 1) * longint'(cfg_side) * FX_ONE;
        s   = longint'(origin) * FX_ONE + num / (2 * OUT_SIDE) - FX_HALF;
        a   = s >>> FX_SH;
        if (a < 0)
            a = 0;
        if (a > extent - 1)
            a = extent - 1;
        lo = a;
        hi = (a + 1 < extent - 1) ? a + 1 : extent - 1;
        wt = s - a * FX_ONE;
        if (wt < 0)
            wt = 0;
        if (wt > FX_ONE)
            wt = FX_ONE;
    endfunction

    function automatic logic [23:0] pixel_at(input longint x, input longint y);
        int key;
        key = int'(y * MAX_WIDTH + x);
        return src_pixels.exists(key) ? src_pixels[key] : 24'h0;
    endfunction

    // Expected 8.8 RGB for one output position under the current registers
    function automatic brc_rsp_t interp_rgb(input logic [8:0] oc, input logic [8:0] orr);
        longint            x0, x1, fx, y0, y1, fy;
        logic [23:0]       p00, p01, p10, p11;
        longint unsigned   gx, ux, gy, uy, a, b, d, e, top, bot, acc;
        logic [15:0]       ch [3];
        brc_rsp_t          res;
        map_axis(cfg_cx, oc, eff_extent(cfg_w, MAX_WIDTH), x0, x1, fx);
        map_axis(cfg_cy, orr, eff_extent(cfg_h, MAX_HEIGHT), y0, y1, fy);
        p00 = pixel_at(x0, y0);
        p01 = pixel_at(x1, y0);
        p10 = pixel_at(x0, y1);
        p11 = pixel_at(x1, y1);
        gx  = FX_ONE - fx;
        ux  = fx;
        gy  = FX_ONE - fy;
        uy  = fy;
        // red, green, blue from the top byte down; horizontal pass, then vertical
        for (int c = 0; c < 3; c++) begin
            a     = p00[16 - 8 * c +: 8];
            b     = p01[16 - 8 * c +: 8];
            d     = p10[16 - 8 * c +: 8];
            e     = p11[16 - 8 * c +: 8];
            top   = a * gx + b * ux;
            bot   = d * gx + e * ux;
            acc   = (top * gy + bot * uy) >> 24;
            ch[c] = acc[15:0];
        end
        res.res_red   = ch[0];
        res.res_green = ch[1];
        res.res_blue  = ch[2];
        return res;
    endfunction

    function automatic brc_req_t make_write(input logic [9:0] col, input logic [9:0] row,
                                            input logic [23:0] rgb);
        brc_req_t it;
        it.op      = OP_WRITE;
        it.pix_col = col;
        it.pix_row = row;
        {it.in_red, it.in_green, it.in_blue} = rgb;
        it.out_col = 9'($urandom);
        it.out_row = 9'($urandom);
        return it;
    endfunction

    function automatic brc_req_t make_sample(input logic [8:0] oc, input logic [8:0] orr);
        brc_req_t it;
        it.op      = OP_SAMPLE;
        it.pix_col = 10'($urandom);
        it.pix_row = 10'($urandom);
        {it.in_red, it.in_green, it.in_blue} = 24'($urandom);
        it.out_col = oc;
        it.out_row = orr;
        return it;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive one request transaction, then update the shadow once it is taken
    task automatic send_item(input brc_req_t item, input bit known = 1'b0,
                             input brc_rsp_t want = '0);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        if (item.op == OP_WRITE)
            src_pixels[int'(item.pix_row) * MAX_WIDTH + int'(item.pix_col)] =
                {item.in_red, item.in_green, item.in_blue};
        else
            pending_rgb.push_back(known ? want : interp_rgb(item.out_col, item.out_row));
    endtask

    // Checks only after waiting on the clock, so valid is never driven twice in a step
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_rgb.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (brc_cfg_e'(idx))
            CFG_SRC_WIDTH:  cfg_w    = val;
            CFG_SRC_HEIGHT: cfg_h    = val;
            CFG_CROP_X:     cfg_cx   = val[9:0];
            CFG_CROP_Y:     cfg_cy   = val[9:0];
            CFG_CROP_SIDE:  cfg_side = val;
            default: ;
        endcase
    endtask

    // Registers change only with the block idle: drained, then in-flight writes settled
    task automatic program_regs(input plan_t pc, input bit poke_unused);
        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_SRC_WIDTH, pc.w);
        write_reg(CFG_SRC_HEIGHT, pc.h);
        write_reg(CFG_CROP_X, pc.cx);
        write_reg(CFG_CROP_Y, pc.cy);
        write_reg(CFG_CROP_SIDE, pc.side);
        // indices past the last register must be ignored
        if (poke_unused)
            for (int k = CFG_CROP_SIDE + 1; k < 2 ** CFG_IDX_W; k++)
                write_reg(CFG_IDX_W'(k), CFG_DW'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Write every neighbour a sample will read that has not been written yet
    task automatic fill_taps(input logic [8:0] oc, input logic [8:0] orr);
        longint xs [2];
        longint ys [2];
        longint fx, fy;
        map_axis(cfg_cx, oc, eff_extent(cfg_w, MAX_WIDTH), xs[0], xs[1], fx);
        map_axis(cfg_cy, orr, eff_extent(cfg_h, MAX_HEIGHT), ys[0], ys[1], fy);
        for (int j = 0; j < 2; j++)
            for (int i = 0; i < 2; i++)
                if (!src_pixels.exists(int'(ys[j] * MAX_WIDTH + xs[i])))
                    send_item(make_write(10'(xs[i]), 10'(ys[j]), 24'($urandom)));
    endtask

    // Random segment: mostly samples over filled neighbours, plus image and stray writes
    task automatic run_random(input int count);
        int          stop;
        int          roll;
        int          w;
        int          h;
        bit          paused;
        logic [8:0]  oc;
        logic [8:0]  orr;
        stop   = items_sent + count;
        paused = 1'b0;
        w      = int'(eff_extent(cfg_w, MAX_WIDTH));
        h      = int'(eff_extent(cfg_h, MAX_HEIGHT));
        while (items_sent < stop)
        begin
            // halfway through, hold off until every result is back
            if (!paused && items_sent >= stop - count / 2)
            begin
                req_ch.valid <= 1'b0;
                wait_drained();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                oc  = ($urandom_range(0, 4) == 0) ? 9'($urandom)
                                                  : 9'($urandom_range(0, OUT_SIDE - 1));
                orr = ($urandom_range(0, 4) == 0) ? 9'($urandom)
                                                  : 9'($urandom_range(0, OUT_SIDE - 1));
                fill_taps(oc, orr);
                send_item(make_sample(oc, orr));
            end
            else if (roll < 88)
                send_item(make_write(10'($urandom_range(0, w - 1)),
                                     10'($urandom_range(0, h - 1)), 24'($urandom)));
            else
                send_item(make_write(10'($urandom), 10'($urandom), 24'($urandom)));
        end
    endtask

    // Result side: random back-pressure and in-order checking
    initial
    begin : result_side
        int      stall_left;
        brc_rsp_t want;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rgb.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT)
                        $display("%0t: unexpected result r=%h g=%h b=%h", $realtime,
                                 rsp_ch.data.res_red, rsp_ch.data.res_green,
                                 rsp_ch.data.res_blue);
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    if (rsp_ch.data.res_red !== want.res_red ||
                        rsp_ch.data.res_green !== want.res_green ||
                        rsp_ch.data.res_blue !== want.res_blue)
                    begin
                        bad_results++;
                        if (bad_results <= REPORT_LIMIT)
                            $display("%0t: mismatch exp r=%h g=%h b=%h got r=%h g=%h b=%h",
                                     $realtime, want.res_red, want.res_green,
                                     want.res_blue, rsp_ch.data.res_red,
                                     rsp_ch.data.res_green, rsp_ch.data.res_blue);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left   = $urandom_range(1, 12) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus: reset, directed rows, then one random segment per register setting
    initial
    begin : stimulus
        plan_t pc;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tab[i])
            send_item(directed_tab[i].stim, directed_tab[i].known, directed_tab[i].want);
        run_random(ITEMS_PER_SEG);

        for (int p = 0; p < NUM_PLANS; p++)
        begin
            if (p < FIXED_PLANS)
                pc = fixed_plan[p];
            else
            begin
                pc.w    = CFG_DW'($urandom_range(1, 64));
                pc.h    = CFG_DW'($urandom_range(1, 64));
                pc.cx   = CFG_DW'($urandom_range(0, 40));
                pc.cy   = CFG_DW'($urandom_range(0, 40));
                pc.side = CFG_DW'($urandom_range(1, 80));
            end
            program_regs(pc, p == 2);
            // final segment runs with no random idling on either side
            calm = (p == NUM_PLANS - 1);
            run_random(ITEMS_PER_SEG);
        end

        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
